// ===== hdl/weighted_key_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Weighted key priority queue assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_KEY_PRIORITY_QUEUE_ASSERT_SVH
`define WEIGHTED_KEY_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define WKPQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define WKPQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hdl/wkpq_pkg.sv =====
// ----------------------------------------------------------------------------
// wkpq_pkg
// Shared widths, codes and types of the weighted key priority queue.
// ----------------------------------------------------------------------------
package wkpq_pkg;

	localparam int CAPACITY_DEFAULT = 16;
	localparam int ID_BITS_DEFAULT  = 16;

	localparam int GRADE_BITS   = 8;
	localparam int COURSE_BITS  = 8;
	localparam int WEIGHT_BITS  = 16;
	localparam int PROD_BITS    = GRADE_BITS + WEIGHT_BITS;
	localparam int KEY_BITS     = 25;
	localparam int COUNT_BITS   = 5;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [WEIGHT_BITS-1:0] GRADE_WEIGHT_RESET  = 16'd205;
	localparam logic [WEIGHT_BITS-1:0] COURSE_WEIGHT_RESET = 16'd1170;

	localparam logic [CFG_IDX_BITS-1:0] REG_GRADE_WEIGHT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COURSE_WEIGHT = 2'd1;

	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_DEQUEUE = 1'b1;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_FULL  = 2'd1,
		FAULT_EMPTY = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2
	} cell_op_t;

	// entry contents apart from the id, whose width is a parameter
	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [GRADE_BITS-1:0]  grade;
		logic [COURSE_BITS-1:0] courses;
	} rec_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t op;
		rec_t     rec;
	} cell_cmd_t;

endpackage

// ===== hdl/wkpq_key.sv =====
// ----------------------------------------------------------------------------
// wkpq_key
// Two-stage key datapath: weight products, then their sum.
// ----------------------------------------------------------------------------
module wkpq_key (
	input  logic                               clk,
	input  logic                               en_s1,
	input  logic                               en_s2,
	input  logic [wkpq_pkg::GRADE_BITS-1:0]    grade,
	input  logic [wkpq_pkg::COURSE_BITS-1:0]   courses,
	input  logic [wkpq_pkg::WEIGHT_BITS-1:0]   grade_weight,
	input  logic [wkpq_pkg::WEIGHT_BITS-1:0]   course_weight,
	output logic [wkpq_pkg::KEY_BITS-1:0]      key_s2
);
	import wkpq_pkg::*;

	logic [PROD_BITS-1:0] prod_g_s1;
	logic [PROD_BITS-1:0] prod_c_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_g_s1 <= grade * grade_weight;
			prod_c_s1 <= courses * course_weight;
		end
		if (en_s2) begin
			key_s2 <= KEY_BITS'(prod_g_s1) + KEY_BITS'(prod_c_s1);
		end
	end

endmodule

// ===== hdl/wkpq_cell.sv =====
// ----------------------------------------------------------------------------
// wkpq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module wkpq_cell #(
	parameter int ID_BITS = wkpq_pkg::ID_BITS_DEFAULT
) (
	input  logic                clk,
	input  wkpq_pkg::cell_cmd_t cmd,
	input  logic [ID_BITS-1:0]  new_id,
	input  logic                occupied,
	input  logic                left_ge,
	input  logic [ID_BITS-1:0]  left_id,
	input  wkpq_pkg::rec_t      left_rec,
	input  logic [ID_BITS-1:0]  right_id,
	input  wkpq_pkg::rec_t      right_rec,
	output logic                ge,
	output logic [ID_BITS-1:0]  id_q,
	output wkpq_pkg::rec_t      rec_q,
	output logic [ID_BITS-1:0]  next_id,
	output wkpq_pkg::rec_t      next_rec
);
	import wkpq_pkg::*;

	// equal keys stay ahead of the newcomer
	assign ge = occupied && (rec_q.key >= cmd.rec.key);

	always_comb begin
		next_id  = id_q;
		next_rec = rec_q;
		unique case (cmd.op)
			OP_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						next_id  = new_id;
						next_rec = cmd.rec;
					end else begin
						next_id  = left_id;
						next_rec = left_rec;
					end
				end
			end
			OP_POP: begin
				next_id  = right_id;
				next_rec = right_rec;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		id_q  <= next_id;
		rec_q <= next_rec;
	end

endmodule

// ===== hdl/weighted_key_priority_queue.sv =====
// ----------------------------------------------------------------------------
// weighted_key_priority_queue
// Bounded priority queue sorted by descending weighted key, built as a chain
// of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 enqueues elem_id, grade and
//   courses; mode 1 dequeues the front entry. Key is
//   grade * grade_weight + courses * course_weight, 16 fractional bits.
//   Output channel (out_valid / out_stall): one result per input transfer:
//   the front entry, entry_count, is_empty and fault (dropped enqueue while
//   full, dropped dequeue while empty). Results come in input order.
//   Path: products at the input transfer edge, key sum when stage 1
//   advances, then chain update with result capture when stage 2
//   advances; a stalled output holds items back between these steps.
//   Throughput: one item per cycle while out_stall is low; every cell compares
//   against the broadcast key in parallel, so the chain inserts or pops at once.
//   Configuration (cfg_valid / cfg_ready): index 0 grade_weight, index 1
//   course_weight; other indexes are ignored. Write only while idle.
//   Reset: queue empty, weights to 205 and 1170; no clearing pass, slot
//   contents are simply left alone until written.
//   Stall: a stalled result holds; one more item may sit in each of the two
//   key stages, after which in_stall rises.
// ----------------------------------------------------------------------------
`include "weighted_key_priority_queue_assert.svh"

module weighted_key_priority_queue #(
	parameter int CAPACITY = wkpq_pkg::CAPACITY_DEFAULT,
	parameter int ID_BITS  = wkpq_pkg::ID_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wkpq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wkpq_pkg::WEIGHT_BITS-1:0]     cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [ID_BITS-1:0]                   elem_id,
	input  logic [wkpq_pkg::GRADE_BITS-1:0]      grade,
	input  logic [wkpq_pkg::COURSE_BITS-1:0]     courses,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ID_BITS-1:0]                   front_id,
	output logic [wkpq_pkg::GRADE_BITS-1:0]      front_grade,
	output logic [wkpq_pkg::COURSE_BITS-1:0]     front_courses,
	output logic [wkpq_pkg::KEY_BITS-1:0]        front_key,
	output logic [wkpq_pkg::COUNT_BITS-1:0]      entry_count,
	output logic                                 is_empty,
	output logic [1:0]                           fault
);
	import wkpq_pkg::*;

	localparam int              CNT_BITS = $clog2(CAPACITY + 1);
	localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

	// config registers
	logic [WEIGHT_BITS-1:0] grade_weight_q;
	logic [WEIGHT_BITS-1:0] course_weight_q;

	// pipeline control and carried payload
	logic                   valid_s1, valid_s2;
	logic                   mode_s1, mode_s2;
	logic [ID_BITS-1:0]     id_s1, id_s2;
	logic [GRADE_BITS-1:0]  grade_s1, grade_s2;
	logic [COURSE_BITS-1:0] courses_s1, courses_s2;
	logic [KEY_BITS-1:0]    key_s2;
	logic                   in_xfer, s1_adv, s2_adv;

	// queue state
	logic [CNT_BITS-1:0]    count_q, count_d;
	cell_cmd_t              cmd;
	fault_t                 fault_d;

	// result register
	logic                   out_valid_q;
	logic [ID_BITS-1:0]     front_id_q;
	rec_t                   front_rec_q;
	logic [COUNT_BITS-1:0]  count_out_q;
	logic                   empty_q;
	fault_t                 fault_q;

	// chain wiring
	logic                   cell_ge   [CAPACITY];
	logic                   cell_occ  [CAPACITY];
	logic [ID_BITS-1:0]     cell_id   [CAPACITY];
	rec_t                   cell_rec  [CAPACITY];
	logic                   lft_ge    [CAPACITY];
	logic [ID_BITS-1:0]     lft_id    [CAPACITY];
	rec_t                   lft_rec   [CAPACITY];
	logic [ID_BITS-1:0]     rgt_id    [CAPACITY];
	rec_t                   rgt_rec   [CAPACITY];
	logic [ID_BITS-1:0]     head_nxt_id;
	rec_t                   head_nxt_rec;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grade_weight_q  <= GRADE_WEIGHT_RESET;
			course_weight_q <= COURSE_WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRADE_WEIGHT:  grade_weight_q  <= cfg_data;
				REG_COURSE_WEIGHT: course_weight_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------- handshake and stage advance ----------------
	// s2 applies its item to the chain and captures the result at the same edge,
	// so it moves only when the result register is free or being drained.
	assign s2_adv   = valid_s2 && (!out_valid_q || !out_stall);
	assign s1_adv   = valid_s1 && (!valid_s2 || s2_adv);
	assign in_stall = valid_s1 && valid_s2 && !s2_adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			valid_s1    <= in_xfer || (valid_s1 && !s1_adv);
			valid_s2    <= s1_adv || (valid_s2 && !s2_adv);
			out_valid_q <= s2_adv || (out_valid_q && out_stall);
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1    <= mode;
			id_s1      <= elem_id;
			grade_s1   <= grade;
			courses_s1 <= courses;
		end
		if (s1_adv) begin
			mode_s2    <= mode_s1;
			id_s2      <= id_s1;
			grade_s2   <= grade_s1;
			courses_s2 <= courses_s1;
		end
	end

	wkpq_key u_key (
		.clk           (clk),
		.en_s1         (in_xfer),
		.en_s2         (s1_adv),
		.grade         (grade),
		.courses       (courses),
		.grade_weight  (grade_weight_q),
		.course_weight (course_weight_q),
		.key_s2        (key_s2)
	);

	// ---------------- command decision ----------------
	// Full and empty are judged on the count left by every earlier item.
	always_comb begin
		cmd.op          = OP_HOLD;
		cmd.rec.key     = key_s2;
		cmd.rec.grade   = grade_s2;
		cmd.rec.courses = courses_s2;
		fault_d         = FAULT_NONE;
		count_d         = count_q;
		if (s2_adv) begin
			if (mode_s2 == MODE_ENQUEUE) begin
				if (count_q == CAP_CNT) begin
					fault_d = FAULT_FULL;
				end else begin
					cmd.op  = OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end else begin
				if (count_q == '0) begin
					fault_d = FAULT_EMPTY;
				end else begin
					cmd.op  = OP_POP;
					count_d = count_q - 1'b1;
				end
			end
		end
	end

	// ---------------- cell chain ----------------
	// On insert, cell i takes the new entry where its left neighbor still outranks it,
	// or the left entry where the insertion point lies further left; on pop it takes its right neighbor's.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_occ[i] = (count_q > CNT_BITS'(i));

		if (i == 0) begin : g_head
			assign lft_ge[i]  = 1'b1;
			assign lft_id[i]  = id_s2;
			assign lft_rec[i] = cmd.rec;
		end else begin : g_mid
			assign lft_ge[i]  = cell_ge[i-1];
			assign lft_id[i]  = cell_id[i-1];
			assign lft_rec[i] = cell_rec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rgt_id[i]  = cell_id[i];
			assign rgt_rec[i] = cell_rec[i];
		end else begin : g_body
			assign rgt_id[i]  = cell_id[i+1];
			assign rgt_rec[i] = cell_rec[i+1];
		end

		if (i == 0) begin : g_front
			wkpq_cell #(.ID_BITS(ID_BITS)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.new_id    (id_s2),
				.occupied  (cell_occ[i]),
				.left_ge   (lft_ge[i]),
				.left_id   (lft_id[i]),
				.left_rec  (lft_rec[i]),
				.right_id  (rgt_id[i]),
				.right_rec (rgt_rec[i]),
				.ge        (cell_ge[i]),
				.id_q      (cell_id[i]),
				.rec_q     (cell_rec[i]),
				.next_id   (head_nxt_id),
				.next_rec  (head_nxt_rec)
			);
		end else begin : g_rest
			wkpq_cell #(.ID_BITS(ID_BITS)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.new_id    (id_s2),
				.occupied  (cell_occ[i]),
				.left_ge   (lft_ge[i]),
				.left_id   (lft_id[i]),
				.left_rec  (lft_rec[i]),
				.right_id  (rgt_id[i]),
				.right_rec (rgt_rec[i]),
				.ge        (cell_ge[i]),
				.id_q      (cell_id[i]),
				.rec_q     (cell_rec[i]),
				.next_id   (),
				.next_rec  ()
			);
		end
	end

	// ---------------- result register ----------------
	// Captures the head cell's next value, or zeros once the queue is empty, so the result reflects the step.
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			if (count_d == '0) begin
				front_id_q  <= '0;
				front_rec_q <= '0;
			end else begin
				front_id_q  <= head_nxt_id;
				front_rec_q <= head_nxt_rec;
			end
			count_out_q <= COUNT_BITS'(count_d);
			empty_q     <= (count_d == '0);
			fault_q     <= fault_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign front_id      = front_id_q;
	assign front_grade   = front_rec_q.grade;
	assign front_courses = front_rec_q.courses;
	assign front_key     = front_rec_q.key;
	assign entry_count   = count_out_q;
	assign is_empty      = empty_q;
	assign fault         = fault_q;

	// ---------------- assertions ----------------
	`WKPQ_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_CNT, "count above capacity")
	`WKPQ_ASSERT_IMPLY(a_head_sorted, clk, arst_n, cell_occ[1], cell_rec[0].key >= cell_rec[1].key, "head out of order")
	`WKPQ_ASSERT_IMPLY(a_full_fault, clk, arst_n, out_valid_q && fault_q == FAULT_FULL, count_q == CAP_CNT, "full fault with room")
	`WKPQ_ASSERT_NEXT(a_insert_count, clk, arst_n, cmd.op == OP_INSERT, count_q == $past(count_q) + 1'b1, "insert count slip")

endmodule
